// ----- hdl/two_line_text_terminal_core_assert.svh -----
// ---------------------------------------------------------------------------
// two_line_text_terminal_core assertion macros
// Shared forms for the concurrent checks of the terminal core.
// ---------------------------------------------------------------------------
`ifndef TWO_LINE_TEXT_TERMINAL_CORE_ASSERT_SVH
`define TWO_LINE_TEXT_TERMINAL_CORE_ASSERT_SVH

// same-cycle implication
`define TLT_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("tlt check failed");

// next-cycle implication
`define TLT_ASSERT_NXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("tlt check failed");

`endif

// ----- hdl/tlt_pkg.sv -----
// ---------------------------------------------------------------------------
// tlt_pkg
// Codes and shared types of the two-line text terminal core.
// ---------------------------------------------------------------------------
package tlt_pkg;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_ACK   = 2'd2;

	localparam logic [7:0] CODE_NONE    = 8'h00;
	localparam logic [7:0] CODE_NEWLINE = 8'h0d;
	localparam logic [7:0] CODE_DELETE  = 8'h7f;
	localparam logic [7:0] CODE_SPACE   = 8'h20;

	localparam int COLUMN_W = 4;

	// control of the text store, rows given as logical screen rows
	typedef struct packed {
		logic wr_en;
		logic wr_row;
		logic swap;
		logic rd_row;
	} store_ctl_t;

endpackage

// ----- hdl/tlt_text_store.sv -----
// ---------------------------------------------------------------------------
// tlt_text_store
// Character store for both rows with a row swap used for scrolling.
// ---------------------------------------------------------------------------
module tlt_text_store #(
	parameter int LINE_CHARS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tlt_pkg::store_ctl_t             ctl,
	input  logic [$clog2(LINE_CHARS)-1:0]   wr_idx,
	input  logic [7:0]                      wr_data,
	input  logic [$clog2(LINE_CHARS)-1:0]   rd_idx,
	output logic [7:0]                      rd_data
);

	localparam int IW    = $clog2(LINE_CHARS);
	localparam int DEPTH = 2 ** (IW + 1);

	logic [7:0] mem_q [DEPTH];
	logic       top_q;
	logic [7:0] rd_data_q;
	logic       wr_prow;
	logic       rd_prow;

	// logical row to physical half; scrolling flips the mapping instead of copying
	assign wr_prow = ctl.wr_row ^ top_q;
	assign rd_prow = ctl.rd_row ^ top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q <= 1'b0;
		end else if (ctl.swap) begin
			top_q <= ~top_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[{wr_prow, wr_idx}] <= wr_data;
		end
		rd_data_q <= mem_q[{rd_prow, rd_idx}];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/two_line_text_terminal_core.sv -----
// A taken byte is held in the request registers; results then load one per cycle
// while result_ready is high; redraw cells come from a registered store read.
// A printable byte or newline gives 1 result, or 2 + row length when it scrolls;
// a delete that moves the cursor gives LINE_CHARS + row length results, at most 31
// at 16 columns. rx_ready is low until the last result of a request is loaded.
// Reset clears cursor, row lengths and row mapping; the text store is not cleared.
// ---------------------------------------------------------------------------
// two_line_text_terminal_core
// Two-row text screen keeper emitting cell writes, clears and acknowledges.
// ---------------------------------------------------------------------------
`include "two_line_text_terminal_core_assert.svh"

module two_line_text_terminal_core #(
	parameter int LINE_CHARS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rx_valid,
	output logic       rx_ready,
	input  logic [7:0] rx_byte,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] action,
	output logic       row,
	output logic [3:0] column,
	output logic [7:0] glyph,
	output logic       last
);

	localparam int IW = $clog2(LINE_CHARS);
	localparam int LW = $clog2(LINE_CHARS + 1);
	localparam logic [IW-1:0] LAST_COL = IW'(LINE_CHARS - 1);
	localparam logic [LW-1:0] LEN_FULL = LW'(LINE_CHARS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FIRST = 3'd1;
	localparam logic [2:0] S_CLEAR = 3'd2;
	localparam logic [2:0] S_SPACE = 3'd3;
	localparam logic [2:0] S_DRAW  = 3'd4;

	logic [2:0]    state_q;
	logic [IW-1:0] cnt_q;
	logic [LW-1:0] draw_len_q;
	logic          draw_row_q;
	logic          scroll_q;
	logic [1:0]    first_action_q;
	logic          first_row_q;
	logic [IW-1:0] first_col_q;
	logic [7:0]    first_glyph_q;

	logic          cur_row_q;
	logic [IW-1:0] cur_col_q;
	logic [LW-1:0] len_q [2];

	logic          result_valid_q;
	logic [1:0]    action_q;
	logic          row_q;
	logic [3:0]    column_q;
	logic [7:0]    glyph_q;
	logic          last_q;

	tlt_pkg::store_ctl_t store_ctl;
	logic [IW-1:0] rd_idx;
	logic [7:0]    rd_data;

	logic          take;
	logic          is_zero;
	logic          is_del;
	logic          is_nl;
	logic          is_print;
	logic [LW-1:0] cur_len;
	logic          del_ok;
	logic          del_row;
	logic [LW-1:0] del_len;
	logic          wrap;
	logic          scroll;
	logic          store;
	logic [LW-1:0] len_after;

	logic          emit;
	logic [2:0]    nxt_state;
	logic [1:0]    nxt_action;
	logic          nxt_row;
	logic [IW-1:0] nxt_col;
	logic [7:0]    nxt_glyph;
	logic          nxt_last;
	logic          seq_end;

	function automatic logic [3:0] col_bits(input logic [IW-1:0] c);
		logic [IW+3:0] wide;
		wide = {4'b0000, c};
		return wide[3:0];
	endfunction

	// ------------------------------------------------------------ byte decode
	always_comb begin
		take     = rx_valid && rx_ready;
		is_zero  = (rx_byte == tlt_pkg::CODE_NONE);
		is_del   = (rx_byte == tlt_pkg::CODE_DELETE);
		is_nl    = (rx_byte == tlt_pkg::CODE_NEWLINE);
		is_print = !is_zero && !is_del && !is_nl;
		cur_len  = len_q[cur_row_q];

		// delete steps back, possibly onto the end of the upper row
		del_ok  = (cur_col_q != '0) || cur_row_q;
		del_row = (cur_col_q != '0) ? cur_row_q : 1'b0;
		del_len = (len_q[del_row] != '0) ? len_q[del_row] - LW'(1) : len_q[del_row];

		wrap      = is_nl || (cur_col_q == LAST_COL);
		scroll    = wrap && cur_row_q;
		store     = is_print && (cur_len < LEN_FULL);
		len_after = store ? cur_len + LW'(1) : cur_len;

		store_ctl.wr_en  = take && store;
		store_ctl.wr_row = cur_row_q;
		store_ctl.swap   = take && !is_zero && !is_del && scroll;
		store_ctl.rd_row = draw_row_q;
	end

	// ------------------------------------------------------------- sequencer
	always_comb begin
		emit       = (state_q != S_IDLE) && (!result_valid_q || result_ready);
		nxt_state  = S_IDLE;
		nxt_action = tlt_pkg::ACT_WRITE;
		nxt_row    = draw_row_q;
		nxt_col    = cnt_q;
		nxt_glyph  = rd_data;
		seq_end    = 1'b0;
		case (state_q)
			S_FIRST: begin
				nxt_action = first_action_q;
				nxt_row    = first_row_q;
				nxt_col    = first_col_q;
				nxt_glyph  = first_glyph_q;
				nxt_state  = scroll_q ? S_CLEAR : S_IDLE;
			end
			S_CLEAR: begin
				nxt_action = tlt_pkg::ACT_CLEAR;
				nxt_row    = 1'b0;
				nxt_col    = '0;
				nxt_glyph  = tlt_pkg::CODE_NONE;
				nxt_state  = (draw_len_q != '0) ? S_DRAW : S_IDLE;
			end
			S_SPACE: begin
				nxt_glyph = tlt_pkg::CODE_SPACE;
				seq_end   = (cnt_q == LAST_COL);
				if (seq_end) begin
					nxt_state = (draw_len_q != '0) ? S_DRAW : S_IDLE;
				end else begin
					nxt_state = S_SPACE;
				end
			end
			S_DRAW: begin
				seq_end   = (LW'(cnt_q) + LW'(1) == draw_len_q);
				nxt_state = seq_end ? S_IDLE : S_DRAW;
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
		nxt_last = (nxt_state == S_IDLE);

		// read ahead so the next cell is waiting when the result register frees up
		if (state_q == S_DRAW) begin
			rd_idx = emit ? cnt_q + IW'(1) : cnt_q;
		end else begin
			rd_idx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			cur_row_q <= 1'b0;
			cur_col_q <= '0;
			len_q[0]  <= '0;
			len_q[1]  <= '0;
		end else if (take) begin
			cnt_q <= '0;
			if (is_del) begin
				if (del_ok) begin
					state_q        <= S_SPACE;
					cur_row_q      <= del_row;
					cur_col_q      <= (cur_col_q != '0) ? cur_col_q - IW'(1) : LAST_COL;
					len_q[del_row] <= del_len;
				end
			end else if (!is_zero) begin
				state_q   <= S_FIRST;
				cur_row_q <= wrap ? 1'b1 : cur_row_q;
				cur_col_q <= wrap ? '0 : cur_col_q + IW'(1);
				if (scroll) begin
					len_q[0] <= len_after;
					len_q[1] <= '0;
				end else begin
					len_q[cur_row_q] <= len_after;
				end
			end
		end else if (emit) begin
			state_q <= nxt_state;
			if (state_q == S_SPACE && !seq_end) begin
				cnt_q <= cnt_q + IW'(1);
			end else if (state_q == S_DRAW) begin
				cnt_q <= cnt_q + IW'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

	// details of the request being worked on
	always_ff @(posedge clk) begin
		if (take) begin
			if (is_del) begin
				draw_row_q <= del_row;
				draw_len_q <= del_len;
				scroll_q   <= 1'b0;
			end else begin
				draw_row_q <= 1'b0;
				draw_len_q <= len_after;
				scroll_q   <= scroll;
			end
			first_action_q <= is_nl ? tlt_pkg::ACT_ACK : tlt_pkg::ACT_WRITE;
			first_row_q    <= is_nl ? 1'b0 : cur_row_q;
			first_col_q    <= is_nl ? '0 : cur_col_q;
			first_glyph_q  <= is_nl ? tlt_pkg::CODE_NONE : rx_byte;
		end
	end

	// ------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			action_q <= nxt_action;
			row_q    <= nxt_row;
			column_q <= col_bits(nxt_col);
			glyph_q  <= nxt_glyph;
			last_q   <= nxt_last;
		end
	end

	tlt_text_store #(
		.LINE_CHARS(LINE_CHARS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (store_ctl),
		.wr_idx  (cur_len[IW-1:0]),
		.wr_data (rx_byte),
		.rd_idx  (rd_idx),
		.rd_data (rd_data)
	);

	assign rx_ready     = (state_q == S_IDLE);
	assign result_valid = result_valid_q;
	assign action       = action_q;
	assign row          = row_q;
	assign column       = column_q;
	assign glyph        = glyph_q;
	assign last         = last_q;

	// ------------------------------------------------------------- checks
	`TLT_ASSERT_NXT(a_last_frees_input, clk, arst_n, emit && nxt_last, state_q == S_IDLE)
	`TLT_ASSERT_IMP(a_draw_has_length, clk, arst_n, state_q == S_DRAW, draw_len_q != '0)
	`TLT_ASSERT_IMP(a_len_bounded, clk, arst_n, 1'b1, len_q[0] <= LEN_FULL && len_q[1] <= LEN_FULL)
	`TLT_ASSERT_NXT(a_scroll_clears_lower, clk, arst_n, store_ctl.swap, len_q[1] == '0 && cur_row_q)

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-line text terminal core. A directed table
// covers the reset state, the code extremes, delete at the screen edges and
// scrolling. Random byte streams follow, dominated by long runs of text so
// that rows wrap and scroll. A screen model in the bench predicts every cell
// write, clear and acknowledge.
// ---------------------------------------------------------------------------
module tb_top;

	localparam int LINE_CHARS   = 16;
	localparam int RANDOM_ITEMS = 300;
	localparam int QUIET_ITEMS  = 50;
	localparam int HOLD_AT      = 80;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [1:0] act;
		logic       row_sel;
		logic [3:0] col;
		logic [7:0] ch;
		logic       last_flag;
	} cell_t;

	typedef struct {
		logic [7:0] code;
		bit         typed;
		int         n_typed;
		cell_t      want_cell;
	} stim_row_t;

	localparam cell_t NO_CELL = '0;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       rx_valid = 1'b0;
	logic       rx_ready;
	logic [7:0] rx_byte = tlt_pkg::CODE_NONE;
	logic       result_valid;
	logic       result_ready = 1'b0;
	logic [1:0] action;
	logic       row;
	logic [3:0] column;
	logic [7:0] glyph;
	logic       last;

	// screen model
	logic [7:0] screen_text [2][LINE_CHARS];
	int         line_len [2];
	int         cur_row;
	int         cur_col;

	cell_t step_cells [$];
	cell_t cells_due [$];

	int  error_count = 0;
	int  busy_items = 0;
	int  cycle_count = 0;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  quiet = 1'b0;

	stim_row_t directed_rows [20] = '{
		'{tlt_pkg::CODE_NONE,    1'b1, 0, NO_CELL},
		'{tlt_pkg::CODE_DELETE,  1'b1, 0, NO_CELL},
		'{8'h41, 1'b1, 1, '{tlt_pkg::ACT_WRITE, 1'b0, 4'd0,  8'h41, 1'b1}},
		'{8'hff, 1'b1, 1, '{tlt_pkg::ACT_WRITE, 1'b0, 4'd1,  8'hff, 1'b1}},
		'{8'h01, 1'b1, 1, '{tlt_pkg::ACT_WRITE, 1'b0, 4'd2,  8'h01, 1'b1}},
		'{tlt_pkg::CODE_DELETE,  1'b0, 0, NO_CELL},
		'{tlt_pkg::CODE_NEWLINE, 1'b1, 1, '{tlt_pkg::ACT_ACK, 1'b0, 4'd0, 8'h00, 1'b1}},
		// back from row one to the end of row zero
		'{tlt_pkg::CODE_DELETE,  1'b0, 0, NO_CELL},
		'{tlt_pkg::CODE_DELETE,  1'b0, 0, NO_CELL},
		// row zero now empty, nothing to remove
		'{tlt_pkg::CODE_DELETE,  1'b0, 0, NO_CELL},
		'{tlt_pkg::CODE_NEWLINE, 1'b1, 1, '{tlt_pkg::ACT_ACK, 1'b0, 4'd0, 8'h00, 1'b1}},
		'{tlt_pkg::CODE_NEWLINE, 1'b0, 0, NO_CELL},
		'{tlt_pkg::CODE_DELETE,  1'b0, 0, NO_CELL},
		'{8'h80, 1'b1, 1, '{tlt_pkg::ACT_WRITE, 1'b0, 4'd15, 8'h80, 1'b1}},
		'{8'h7e, 1'b1, 1, '{tlt_pkg::ACT_WRITE, 1'b1, 4'd0,  8'h7e, 1'b1}},
		'{8'h0e, 1'b1, 1, '{tlt_pkg::ACT_WRITE, 1'b1, 4'd1,  8'h0e, 1'b1}},
		'{8'h0c, 1'b1, 1, '{tlt_pkg::ACT_WRITE, 1'b1, 4'd2,  8'h0c, 1'b1}},
		'{tlt_pkg::CODE_DELETE,  1'b0, 0, NO_CELL},
		'{tlt_pkg::CODE_NEWLINE, 1'b0, 0, NO_CELL},
		'{tlt_pkg::CODE_NONE,    1'b1, 0, NO_CELL}
	};

	two_line_text_terminal_core #(.LINE_CHARS(LINE_CHARS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_valid     (rx_valid),
		.rx_ready     (rx_ready),
		.rx_byte      (rx_byte),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.action       (action),
		.row          (row),
		.column       (column),
		.glyph        (glyph),
		.last         (last)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void add_cell(input logic [1:0] act, input int r, input int c,
		input logic [7:0] ch);
		cell_t new_cell;
		new_cell.act = act;
		new_cell.row_sel = r[0];
		new_cell.col = c[3:0];
		new_cell.ch = ch;
		new_cell.last_flag = 1'b0;
		step_cells.push_back(new_cell);
	endfunction

	function automatic void redraw_row(input int r);
		for (int i = 0; i < line_len[r] && i < LINE_CHARS; i++)
			add_cell(tlt_pkg::ACT_WRITE, r, i, screen_text[r][i]);
	endfunction

	// updates the screen model for one request and fills step_cells
	function automatic void terminal_step(input logic [7:0] code);
		int line;
		line = cur_row;
		step_cells.delete();
		if (code == tlt_pkg::CODE_NONE)
			return;
		if (code == tlt_pkg::CODE_DELETE) begin
			if (cur_col != 0) begin
				cur_col--;
			end else if (line != 0) begin
				line = 0;
				cur_row = 0;
				cur_col = LINE_CHARS - 1;
			end else begin
				return;
			end
			if (line_len[line] > 0)
				line_len[line]--;
			for (int i = 0; i < LINE_CHARS; i++)
				add_cell(tlt_pkg::ACT_WRITE, line, i, tlt_pkg::CODE_SPACE);
			redraw_row(line);
		end else begin
			if (code == tlt_pkg::CODE_NEWLINE) begin
				line++;
				cur_col = 0;
				add_cell(tlt_pkg::ACT_ACK, 0, 0, 8'h00);
			end else begin
				add_cell(tlt_pkg::ACT_WRITE, line, cur_col, code);
				if (line_len[line] < LINE_CHARS) begin
					screen_text[line][line_len[line]] = code;
					line_len[line]++;
				end
				if (cur_col > LINE_CHARS - 2) begin
					line++;
					cur_col = 0;
				end else begin
					cur_col++;
				end
			end
			// past the second row: scroll up
			if (line > 1) begin
				line = 1;
				screen_text[0] = screen_text[1];
				line_len[0] = line_len[1];
				add_cell(tlt_pkg::ACT_CLEAR, 0, 0, 8'h00);
				redraw_row(0);
				line_len[1] = 0;
			end
			cur_row = line;
		end
		if (step_cells.size() > 0)
			step_cells[step_cells.size() - 1].last_flag = 1'b1;
	endfunction

	task automatic send_code(input logic [7:0] code, input bit typed, input int n_typed,
		input cell_t want_cell);
		int gap;
		rx_valid <= 1'b1;
		rx_byte <= code;
		do @(posedge clk); while (!rx_ready);
		terminal_step(code);
		if (step_cells.size() > 0)
			busy_items++;
		if (typed) begin
			if (n_typed > 0)
				cells_due.push_back(want_cell);
		end else begin
			foreach (step_cells[i])
				cells_due.push_back(step_cells[i]);
		end
		if (busy_items >= HOLD_AT)
			hold_req = 1'b1;
		if (busy_items >= RANDOM_ITEMS - QUIET_ITEMS)
			quiet = 1'b1;
		if (!quiet && hold_left == 0 && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			rx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] text_code();
		logic [7:0] v;
		do v = 8'($urandom_range(1, 255));
		while (v == tlt_pkg::CODE_NEWLINE || v == tlt_pkg::CODE_DELETE);
		return v;
	endfunction

	// result side: checking, random stalls and the long hold-off
	initial begin : result_sink
		int stall_left;
		bit hold_done;
		logic next_ready;
		cell_t exp_cell;
		stall_left = 0;
		hold_done = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				if (cells_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result act=%0d row=%0d col=%0d ch=%02h",
						action, row, column, glyph));
				end else begin
					exp_cell = cells_due.pop_front();
					if (action !== exp_cell.act)
						report_mismatch($sformatf("action %0d, expected %0d",
							action, exp_cell.act));
					if (row !== exp_cell.row_sel)
						report_mismatch($sformatf("row %0d, expected %0d",
							row, exp_cell.row_sel));
					if (column !== exp_cell.col)
						report_mismatch($sformatf("column %0d, expected %0d",
							column, exp_cell.col));
					if (glyph !== exp_cell.ch)
						report_mismatch($sformatf("glyph %02h, expected %02h",
							glyph, exp_cell.ch));
					if (last !== exp_cell.last_flag)
						report_mismatch($sformatf("last %0d, expected %0d",
							last, exp_cell.last_flag));
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_ready = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 4) - 1;
				next_ready = 1'b0;
			end else begin
				next_ready = 1'b1;
			end
			result_ready <= next_ready;
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("simulation failed");
		$finish;
	end

	initial begin : byte_source
		int pick;
		int run_len;
		for (int r = 0; r < 2; r++) begin
			line_len[r] = 0;
			for (int i = 0; i < LINE_CHARS; i++)
				screen_text[r][i] = 8'h00;
		end
		cur_row = 0;
		cur_col = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_code(directed_rows[i].code, directed_rows[i].typed,
				directed_rows[i].n_typed, directed_rows[i].want_cell);
		busy_items = 0;

		while (busy_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				// runs of text long enough to wrap and scroll
				run_len = $urandom_range(1, 40);
				repeat (run_len) send_code(text_code(), 1'b0, 0, NO_CELL);
			end else if (pick < 65) begin
				send_code(tlt_pkg::CODE_NEWLINE, 1'b0, 0, NO_CELL);
			end else if (pick < 85) begin
				run_len = $urandom_range(1, 3);
				repeat (run_len) send_code(tlt_pkg::CODE_DELETE, 1'b0, 0, NO_CELL);
			end else if (pick < 92) begin
				send_code(tlt_pkg::CODE_NONE, 1'b0, 0, NO_CELL);
			end else begin
				send_code(8'($urandom_range(0, 255)), 1'b0, 0, NO_CELL);
			end
		end
		rx_valid <= 1'b0;

		while (cells_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
